// File: hdl/round_robin_quantum_queue_defines.svh
// Assertion macros shared by the queue RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ROUND_ROBIN_QUANTUM_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_QUEUE_DEFINES_SVH

`define RRQQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RRQQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rrqq_pkg.sv
`timescale 1ns / 1ps

package rrqq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 16;
  localparam int CFG_W           = 16;

  localparam logic [CFG_W-1:0] QUANTUM_RST = CFG_W'(1);

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_REPORT   = 2'd2;

  localparam logic [2:0] ST_ADDED        = 3'd0;
  localparam logic [2:0] ST_IGNORED      = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_REQUEUED     = 3'd3;
  localparam logic [2:0] ST_FINISHED     = 3'd4;
  localparam logic [2:0] ST_EMPTY        = 3'd5;
  localparam logic [2:0] ST_REPORT_EMPTY = 3'd6;
  localparam logic [2:0] ST_REPORT_VALID = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DISP = 3'b010,
    S_DIV  = 3'b100
  } state_t;

endpackage

// File: hdl/rrqq_ram.sv
`timescale 1ns / 1ps

module rrqq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rrqq_div.sv
`timescale 1ns / 1ps

module rrqq_div #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 7,
  parameter int QUO_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] acc_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // One quotient bit per cycle; the quotient bits shift in behind the dividend.
  assign rem_sh  = {rem_r[DVS_W-1:0], acc_r[DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub : rem_sh;
    end
  end

  assign done     = done_r;
  assign quotient = acc_r[QUO_W-1:0];

endmodule

// File: hdl/round_robin_quantum_queue.sv
`timescale 1ns / 1ps
// Round-robin job queue with a fixed time quantum.
// Input channel: in_valid / in_stall with in_command and in_burst_time. Result
// channel: out_valid / out_stall with status, run time, average and job count.
// Configuration: cfg_wr_en writes cfg_wr_data into the time quantum at once.
// Every command but the unused code 3 gives exactly one result item.
// Add commands and empty dispatches or reports give their result in the cycle
// after acceptance, and a new item can be taken every cycle while no result
// waits under out_stall. A dispatch reads the job memory and writes the
// requeued job back in the following cycle; the memory read is registered,
// and no new item is taken until the write-back is done. A report with jobs
// queued runs a restoring divider, one quotient bit per cycle over TIME_BITS +
// clog2(QUEUE_DEPTH + 1) + 8 bits; no new item is taken until it is done.
// Reset empties the queue and sets the quantum to 1; the job memory is not
// cleared, as no entry is read before it has been written.
// While a result waits under out_stall no new item is accepted; the result
// register holds its contents until it is taken.
`include "round_robin_quantum_queue_defines.svh"

module round_robin_quantum_queue #(
  parameter int QUEUE_DEPTH = rrqq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = rrqq_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [rrqq_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_command,
  input  logic [TIME_BITS-1:0]                 in_burst_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_status,
  output logic [TIME_BITS-1:0]                 out_run_time,
  output logic [TIME_BITS+7:0]                 out_average_fixed,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_jobs_waiting
);

  import rrqq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = TIME_BITS + CNT_W;
  localparam int DVD_W = SUM_W + 8;
  localparam int AVG_W = TIME_BITS + 8;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   oldest_r, oldest_nxt;
  logic [PTR_W-1:0]   newest_r, newest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CFG_W-1:0]   quantum_r;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, status_nxt;
  logic [TIME_BITS-1:0] out_run_r, run_nxt;
  logic [AVG_W-1:0]   out_avg_r, avg_nxt;
  logic [CNT_W-1:0]   out_jobs_r, jobs_nxt;
  logic               load;

  logic               in_accept;
  logic [TIME_BITS-1:0] q_time;
  logic [TIME_BITS-1:0] job_time;
  logic [TIME_BITS-1:0] job_left;
  logic               requeue;
  logic [PTR_W-1:0]   oldest_inc;
  logic [PTR_W-1:0]   newest_inc;

  logic               ram_we;
  logic [TIME_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [TIME_BITS-1:0] ram_rdata;

  logic               div_start;
  logic               div_done;
  logic [AVG_W-1:0]   div_quo;

  rrqq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  rrqq_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W),
    .QUO_W (AVG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, 8'b0}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign q_time     = TIME_BITS'(quantum_r);
  assign job_time   = ram_rdata;
  assign requeue    = job_time > q_time;
  assign job_left   = job_time - q_time;
  assign oldest_inc = (oldest_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(oldest_r + 1'b1);
  assign newest_inc = (newest_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(newest_r + 1'b1);

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    ram_we     = 1'b0;
    ram_wdata  = in_burst_time;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    status_nxt = ST_ADDED;
    run_nxt    = '0;
    avg_nxt    = '0;
    jobs_nxt   = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_command)
            CMD_ADD: begin
              load = 1'b1;
              if (in_burst_time == '0) begin
                status_nxt = ST_IGNORED;
              end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                newest_nxt = newest_inc;
                count_nxt  = count_r + 1'b1;
                sum_nxt    = sum_r + SUM_W'(in_burst_time);
                jobs_nxt   = count_r + 1'b1;
              end
            end
            CMD_DISPATCH: begin
              if (count_r == '0) begin
                load       = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_DISP;
              end
            end
            CMD_REPORT: begin
              if (count_r == '0) begin
                load       = 1'b1;
                status_nxt = ST_REPORT_EMPTY;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DISP: begin
        load       = 1'b1;
        state_nxt  = S_IDLE;
        oldest_nxt = oldest_inc;
        if (requeue) begin
          ram_we     = 1'b1;
          ram_wdata  = job_left;
          newest_nxt = newest_inc;
          sum_nxt    = sum_r - SUM_W'(q_time);
          run_nxt    = q_time;
          status_nxt = ST_REQUEUED;
        end else begin
          count_nxt  = count_r - 1'b1;
          sum_nxt    = sum_r - SUM_W'(job_time);
          run_nxt    = job_time;
          status_nxt = ST_FINISHED;
          jobs_nxt   = count_r - 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          load       = 1'b1;
          state_nxt  = S_IDLE;
          status_nxt = ST_REPORT_VALID;
          avg_nxt    = div_quo;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      quantum_r   <= QUANTUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= status_nxt;
      out_run_r    <= run_nxt;
      out_avg_r    <= avg_nxt;
      out_jobs_r   <= jobs_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_run_time      = out_run_r;
  assign out_average_fixed = out_avg_r;
  assign out_jobs_waiting  = out_jobs_r;

  `RRQQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "job count beyond depth")
  `RRQQ_ASSERT_IMPL(a_disp_nonempty, state_r == S_DISP, count_r != '0, "dispatch on empty queue")
  `RRQQ_ASSERT_IMPL(a_div_done_state, div_done, state_r == S_DIV, "divider finished while not in use")
  `RRQQ_ASSERT_IMPL(a_load_free, load, !out_valid_r || !out_stall, "waiting result overwritten")
  `RRQQ_ASSERT_NEXT(a_add_result, in_accept && in_command == CMD_ADD, out_valid_r, "add gave no item")

endmodule
